[design/rtb_pkg.sv]
package rtb_pkg;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [1:0] KIND_EXPIRY = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;

  typedef struct packed {
    logic [31:0] period;
    logic [31:0] remaining;
    logic [31:0] repeats;
    logic [7:0]  handler;
  } slot_entry_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] slot;
    logic [7:0] hid;
    logic       last;
  } result_t;

  typedef struct packed {
    logic load;
    logic stop;
    logic walk;
    logic commit;
    logic flush;
  } rtb_cmd_t;

  typedef struct packed {
    logic stall;
    logic hit;
    logic tick;
    logic pend_v;
    logic out_free;
  } rtb_status_t;

endpackage

[design/repeating_timer_bank.sv]
// Bank of SLOTS repeating countdown timers. Send a tick, start or stop as one
// input transaction (op in in_tuser). A tick walks the slot RAM one slot per
// cycle; a start walks the same way, looking for a matching active slot and
// the lowest free one; a match ends the walk, else it commits, claiming the
// free slot or refusing. A stop is handled in the idle state without a walk.
// The single slot RAM read port sets the walk rate, a stalled output pauses
// the walk while more than one expiry is waiting, and the final result of an
// item waits for the output register before the next transaction is taken.
// Each start yields one result, each tick one result per expiring slot with a
// handler (at most eight), with out_tlast on the final one; a tick with no
// expiry and a stop yield nothing.
module repeating_timer_bank
  import rtb_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // duration, repeats, handler, slot_to_stop
  input  logic [1:0]            in_tuser,   // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // slot, fired_handler
  output logic [1:0]            out_tuser,  // kind
  output logic                  out_tlast
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  rtb_cmd_t      cmd;
  rtb_status_t   status;
  logic [IW-1:0] idx, raddr;

  rtb_ctrl #(
    .SLOTS(SLOTS),
    .IW   (IW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_op    (in_tuser),
    .status   (status),
    .cmd      (cmd),
    .idx      (idx),
    .raddr    (raddr)
  );

  rtb_datapath #(
    .SLOTS(SLOTS),
    .IW   (IW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .idx            (idx),
    .raddr          (raddr),
    .status         (status),
    .in_op          (in_tuser),
    .in_duration    (in_tdata[31:0]),
    .in_repeats     (in_tdata[63:32]),
    .in_handler     (in_tdata[71:64]),
    .in_slot_to_stop(in_tdata[74:72]),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast)
  );

endmodule

[design/rtb_datapath.sv]
module rtb_datapath
  import rtb_pkg::*;
#(
  parameter int SLOTS = 8,
  parameter int IW    = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtb_cmd_t              cmd,
  input  logic [IW-1:0]         idx,
  input  logic [IW-1:0]         raddr,
  output rtb_status_t           status,
  input  logic [1:0]            in_op,
  input  logic [31:0]           in_duration,
  input  logic [31:0]           in_repeats,
  input  logic [7:0]            in_handler,
  input  logic [2:0]            in_slot_to_stop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  slot_entry_t mem [SLOTS];
  slot_entry_t rd_q_r;

  logic [SLOTS-1:0] active_r, active_nxt;
  logic             tick_r;
  logic [31:0]      dur_r, rep_r;
  logic [7:0]       hid_r;
  logic             free_v_r, free_v_nxt;
  logic [IW-1:0]    free_idx_r, free_idx_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             pend_v_r, pend_v_nxt;
  result_t          pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r, out_nxt;

  logic             we;
  logic [IW-1:0]    waddr;
  slot_entry_t      wdata;

  logic             act, tick_dec, expire, emit, hit, out_free;
  logic [31:0]      rem1;
  logic [6:0]       idx7, free7, stop7;
  logic [IW-1:0]    stop_idx;
  logic             stop_ok;

  assign idx7     = 7'(idx);
  assign free7    = 7'(free_idx_r);
  assign stop7    = {4'b0, in_slot_to_stop};
  assign stop_idx = stop7[IW-1:0];
  assign stop_ok  = 32'(in_slot_to_stop) < SLOTS;

  assign act      = active_r[idx];
  assign tick_dec = act && (rd_q_r.remaining != 32'd0);
  assign rem1     = rd_q_r.remaining - 32'd1;
  assign expire   = tick_dec && (rem1 == 32'd0);
  assign emit     = tick_r && expire && (rd_q_r.handler != 8'd0) && !cnt_r[3];
  assign hit      = !tick_r && act && (rd_q_r.period == dur_r) &&
                    (rd_q_r.repeats == rep_r) && (rd_q_r.handler == hid_r);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    status.stall    = emit && pend_v_r && !out_free;
    status.hit      = hit;
    status.tick     = tick_r;
    status.pend_v   = pend_v_r;
    status.out_free = out_free;
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rd_q_r;
    if (cmd.walk) begin
      if (tick_r) begin
        if (tick_dec) begin
          we              = 1'b1;
          wdata.remaining = rem1;
          if (expire && (rd_q_r.repeats != 32'd0)) begin
            wdata.remaining = rd_q_r.period;
            if (!rd_q_r.repeats[31]) begin
              wdata.repeats = rd_q_r.repeats - 32'd1;
            end
          end
        end
      end else if (hit) begin
        we              = 1'b1;
        wdata.remaining = dur_r;
      end
    end
    if (cmd.commit && free_v_r) begin
      we    = 1'b1;
      waddr = free_idx_r;
      wdata = '{period: dur_r, remaining: dur_r, repeats: rep_r, handler: hid_r};
    end
  end

  always_comb begin
    active_nxt    = active_r;
    free_v_nxt    = free_v_r;
    free_idx_nxt  = free_idx_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_nxt       = out_r;

    if (cmd.load) begin
      free_v_nxt = 1'b0;
      cnt_nxt    = 4'd0;
    end
    if (cmd.stop && stop_ok) begin
      active_nxt[stop_idx] = 1'b0;
    end
    if (cmd.walk) begin
      if (tick_r) begin
        if (expire && (rd_q_r.repeats == 32'd0)) begin
          active_nxt[idx] = 1'b0;
        end
        if (emit) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = pend_r;
            out_nxt.last  = 1'b0;
          end
          pend_v_nxt = 1'b1;
          pend_nxt   = '{kind: KIND_EXPIRY, slot: idx7[2:0], hid: rd_q_r.handler, last: 1'b0};
          cnt_nxt    = cnt_r + 4'd1;
        end
      end else if (hit) begin
        pend_v_nxt = 1'b1;
        pend_nxt   = '{kind: KIND_ACCEPT, slot: idx7[2:0], hid: 8'd0, last: 1'b0};
      end else if (!act && !free_v_r) begin
        free_v_nxt   = 1'b1;
        free_idx_nxt = idx;
      end
    end
    if (cmd.commit) begin
      pend_v_nxt = 1'b1;
      if (free_v_r) begin
        active_nxt[free_idx_r] = 1'b1;
        pend_nxt = '{kind: KIND_ACCEPT, slot: free7[2:0], hid: 8'd0, last: 1'b0};
      end else begin
        pend_nxt = '{kind: KIND_FULL, slot: 3'd0, hid: 8'd0, last: 1'b0};
      end
    end
    if (cmd.flush) begin
      pend_v_nxt    = 1'b0;
      out_valid_nxt = 1'b1;
      out_nxt       = pend_r;
      out_nxt.last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      free_v_r    <= 1'b0;
      cnt_r       <= 4'd0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      free_v_r    <= free_v_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tick_r <= (in_op == OP_TICK);
      dur_r  <= in_duration;
      rep_r  <= in_repeats;
      hid_r  <= in_handler;
    end
    free_idx_r <= free_idx_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.hid, out_r.slot};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

endmodule

[design/rtb_ctrl.sv]
module rtb_ctrl
  import rtb_pkg::*;
#(
  parameter int SLOTS = 8,
  parameter int IW    = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    in_op,
  input  rtb_status_t   status,
  output rtb_cmd_t      cmd,
  output logic [IW-1:0] idx,
  output logic [IW-1:0] raddr
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_FLUSH  = 2'd3;

  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_tvalid) begin
          unique case (in_op) inside
            OP_TICK, OP_START: begin
              cmd.load  = 1'b1;
              state_nxt = S_WALK;
            end
            OP_STOP: begin
              cmd.stop = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (!status.stall) begin
          cmd.walk = 1'b1;
          if (status.hit) begin
            state_nxt = S_FLUSH;
          end else if (idx_r == LAST) begin
            state_nxt = status.tick ? S_FLUSH : S_COMMIT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FLUSH;
      end
      S_FLUSH: begin
        if (!status.pend_v) begin
          state_nxt = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign idx   = idx_r;
  assign raddr = idx_nxt;

endmodule

[design/rtb_checker.sv]
module rtb_checker
  import rtb_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [1:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser,
  input logic                  out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_START) |=> !in_tready)
    else $error("input taken during start walk");

  a_start_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_EXPIRY) |-> out_tlast)
    else $error("start result not marked last");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_FULL) |-> (out_tdata[10:0] == 11'd0))
    else $error("refused start carries slot or handler");

  a_expiry_hid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_EXPIRY) |-> (out_tdata[10:3] != 8'd0))
    else $error("expiry without handler");

endmodule

bind repeating_timer_bank rtb_checker u_rtb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

[dv/repeating_timer_bank_checker.sv]
module repeating_timer_bank_checker
  import rtb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  out_tlast,
  output int                    mismatches,
  output int                    pending,
  output int                    results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS      = 8;
  localparam int MAX_EXPIRES = 8;

  logic        slot_on     [NSLOTS];
  logic [31:0] slot_period [NSLOTS];
  logic [31:0] slot_left   [NSLOTS];
  logic [31:0] slot_reps   [NSLOTS];
  logic [7:0]  slot_hid    [NSLOTS];
  result_t     timer_events_q [$];

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    mismatches++;
  endtask

  function automatic void advance_timers(input logic [1:0] op, input logic [IN_DATA_W-1:0] d);
    logic [31:0] dur;
    logic [31:0] rep;
    logic [7:0]  hid;
    logic [2:0]  victim;
    int          hit;
    int          fired;
    result_t     r;
    dur    = d[31:0];
    rep    = d[63:32];
    hid    = d[71:64];
    victim = d[74:72];
    fired  = 0;
    hit    = -1;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (slot_on[i] && slot_left[i] != 0) begin
            slot_left[i]--;
            if (slot_left[i] == 0) begin
              if (slot_hid[i] != 0 && fired < MAX_EXPIRES) begin
                r.kind = KIND_EXPIRY;
                r.slot = i[2:0];
                r.hid  = slot_hid[i];
                r.last = 1'b0;
                timer_events_q.push_back(r);
                fired++;
              end
              if (slot_reps[i] == 0) begin
                slot_on[i] = 1'b0;
              end else begin
                if (!slot_reps[i][31]) slot_reps[i]--;
                slot_left[i] = slot_period[i];
              end
            end
          end
        end
        if (fired > 0) timer_events_q[timer_events_q.size()-1].last = 1'b1;
      end
      OP_START: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (hit < 0 && slot_on[i] && slot_period[i] == dur && slot_reps[i] == rep &&
              slot_hid[i] == hid) begin
            slot_left[i] = dur;
            hit = i;
          end
        end
        for (int i = 0; i < NSLOTS; i++) begin
          if (hit < 0 && !slot_on[i]) begin
            slot_period[i] = dur;
            slot_left[i]   = dur;
            slot_reps[i]   = rep;
            slot_hid[i]    = hid;
            slot_on[i]     = 1'b1;
            hit = i;
          end
        end
        r.kind = (hit >= 0) ? KIND_ACCEPT : KIND_FULL;
        r.slot = (hit >= 0) ? hit[2:0] : 3'd0;
        r.hid  = 8'd0;
        r.last = 1'b1;
        timer_events_q.push_back(r);
      end
      OP_STOP: begin
        slot_on[victim] = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NSLOTS; i++) begin
        slot_on[i]     = 1'b0;
        slot_period[i] = '0;
        slot_left[i]   = '0;
        slot_reps[i]   = '0;
        slot_hid[i]    = '0;
      end
      timer_events_q.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (in_tvalid && in_tready) advance_timers(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (timer_events_q.size() == 0) begin
          report_mismatch("unexpected result kind", out_tuser, 0);
        end else begin
          want = timer_events_q.pop_front();
          if (out_tuser !== want.kind) report_mismatch("kind", out_tuser, want.kind);
          if (out_tdata[2:0] !== want.slot) report_mismatch("slot", out_tdata[2:0], want.slot);
          if (out_tdata[10:3] !== want.hid) report_mismatch("handler", out_tdata[10:3], want.hid);
          if (out_tlast !== want.last) report_mismatch("last", out_tlast, want.last);
        end
      end
    end
    pending <= timer_events_q.size();
  end

endmodule

[dv/repeating_timer_bank_tb.sv]
module repeating_timer_bank_tb;
  import rtb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = OP_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  logic                  idle_on = 1'b1;
  logic [3:0]            stall_left = '0;
  int                    idle_cycles = 0;
  int                    mismatches;
  int                    pending;
  int                    results_seen;
  int                    n_tick = 0;
  int                    n_start = 0;
  int                    n_stop = 0;
  int                    n_none = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  repeating_timer_bank DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  repeating_timer_bank_checker timer_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // hold off the result channel in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1'b1;
      out_tready <= 1'b0;
    end else if (rst_n && idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= 4'($urandom_range(0, 7));
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("[repeating_timer_bank] ERROR");
        $finish;
      end
    end
  end

  task automatic send_timer_op(input logic [1:0] op, input logic [31:0] dur,
                               input logic [31:0] rep, input logic [7:0] hid,
                               input logic [2:0] victim);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, victim, hid, rep, dur};
    case (op)
      OP_TICK:  n_tick++;
      OP_START: n_start++;
      OP_STOP:  n_stop++;
      default:  n_none++;
    endcase
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int          sel;
    logic [1:0]  op;
    logic [31:0] dur;
    logic [31:0] rep;
    logic [7:0]  hid;
    logic [2:0]  victim;
    logic [31:0] last_dur;
    logic [31:0] last_rep;
    logic [7:0]  last_hid;
    last_dur = 32'd1;
    last_rep = 32'd0;
    last_hid = 8'd1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_timer_op(OP_TICK,  32'd0, 32'd0, 8'd0, 3'd0);
    send_timer_op(OP_STOP,  32'd0, 32'd0, 8'd0, 3'd7);
    send_timer_op(OP_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 3'd7);
    send_timer_op(OP_START, 32'd1, 32'd0, 8'hFF, 3'd0);
    send_timer_op(OP_START, 32'd0, 32'd0, 8'd1, 3'd0);
    send_timer_op(OP_START, 32'd2, 32'hFFFF_FFFF, 8'd0, 3'd0);
    send_timer_op(OP_START, 32'd2, 32'hFFFF_FFFF, 8'd0, 3'd0);
    send_timer_op(OP_START, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'hAA, 3'd0);
    send_timer_op(OP_START, 32'd3, 32'd2, 8'd7, 3'd0);
    send_timer_op(OP_START, 32'd1, 32'd1, 8'h80, 3'd0);
    send_timer_op(OP_START, 32'd4, 32'd0, 8'h01, 3'd0);
    send_timer_op(OP_START, 32'd5, 32'd0, 8'h02, 3'd0);
    send_timer_op(OP_START, 32'd6, 32'd0, 8'h55, 3'd0);
    send_timer_op(OP_TICK,  32'd0, 32'd0, 8'd0, 3'd0);
    send_timer_op(OP_TICK,  32'd0, 32'd0, 8'd0, 3'd0);
    send_timer_op(OP_TICK,  32'd0, 32'd0, 8'd0, 3'd0);
    send_timer_op(OP_START, 32'd3, 32'd1, 8'd7, 3'd0);
    for (int i = 0; i < 8; i++) send_timer_op(OP_STOP, 32'd0, 32'd0, 8'd0, i[2:0]);
    for (int i = 0; i < 8; i++) send_timer_op(OP_START, 32'd1, 32'd0, 8'(i + 1), 3'd0);
    send_timer_op(OP_TICK,  32'd0, 32'd0, 8'd0, 3'd0);

    for (int k = 0; k < 430; k++) begin
      if (k == 150) idle_on <= 1'b0;
      if (k == 200) idle_on <= 1'b1;
      if (k == 260) drain_results();
      if (k == 370) idle_on <= 1'b0;
      sel = $urandom_range(0, 99);
      op = (sel < 45) ? OP_TICK : (sel < 80) ? OP_START : (sel < 95) ? OP_STOP : OP_NONE;
      case ($urandom_range(0, 9))
        0:       dur = 32'd0;
        1:       dur = $urandom;
        2:       dur = $urandom_range(5, 20);
        default: dur = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: rep = 32'd0;
        4, 5, 6:    rep = $urandom_range(1, 3);
        7, 8:       rep = 32'hFFFF_FFFF;
        default:    rep = $urandom & 32'h7FFF_FFFF;
      endcase
      hid = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      victim = 3'($urandom_range(0, 7));
      if (op == OP_START) begin
        if ($urandom_range(0, 3) == 0) begin
          dur = last_dur;
          rep = last_rep;
          hid = last_hid;
        end
        last_dur = dur;
        last_rep = rep;
        last_hid = hid;
      end
      send_timer_op(op, dur, rep, hid, victim);
    end

    drain_results();
    repeat (40) @(posedge clk);
    $display("sent %0d ticks, %0d starts, %0d stops, %0d unused ops", n_tick, n_start,
             n_stop, n_none);
    $display("compared %0d results under random stalls, a full drain and a stall-free tail",
             results_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("[repeating_timer_bank] OK");
    end else begin
      $display("[repeating_timer_bank] ERROR");
    end
    $finish;
  end

endmodule
